FILE: src/asrenv_pkg.sv
// ----------------------------------------------------------------------------
// ASR envelope package
// Shared widths, defaults and configuration register indexes.
// ----------------------------------------------------------------------------
package asrenv_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 24;
    localparam int SAMPLE_BITS_DEF     = 16;

    localparam int STAGE_W    = 2;
    localparam int DEPTH_W    = 17;
    localparam int DEPTH_FRAC = 16;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(65536);
    localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(32768);

    localparam int RST_THRESHOLD = 16384;
    localparam int RST_STEP      = 350;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_THRESHOLD = 3'd0,
        CFG_ATTACK_STEP    = 3'd1,
        CFG_RELEASE_STEP   = 3'd2,
        CFG_SUSTAIN_LEVEL  = 3'd3,
        CFG_DEPTH          = 3'd4
    } t_cfg_reg;

endpackage

FILE: src/asrenv_in_if.sv
// ----------------------------------------------------------------------------
// ASR envelope gate channel
// Valid/ready channel carrying one gate sample per request.
// ----------------------------------------------------------------------------
interface asrenv_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] ctl_sample;

    modport source (output valid, output ctl_sample, input ready);
    modport sink   (input valid, input ctl_sample, output ready);
endinterface

FILE: src/asrenv_out_if.sv
// ----------------------------------------------------------------------------
// ASR envelope result channel
// Valid/ready channel carrying the scaled envelope value and the stage.
// ----------------------------------------------------------------------------
interface asrenv_out_if
    import asrenv_pkg::*;
#(
    parameter int LEVEL_W = 25
);
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] envelope_value;
    logic [STAGE_W-1:0] stage;

    modport source (output valid, output envelope_value, output stage, input ready);
    modport sink   (input valid, input envelope_value, input stage, output ready);
endinterface

FILE: src/asr_envelope_generator.sv
// Requests pass the update stage register, then the o_env output register.
// Throughput: one request per cycle; a stalled output stalls the input side
// only once the update stage is also full.
// Level update in the first stage, level-by-depth multiply in the second.
// Reset (synchronous, active low) clears level, stage and gate history and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ASR envelope generator
// Gate threshold detection, attack/sustain/release level update and depth
// scaling, with a plain configuration write port.
// ----------------------------------------------------------------------------
module asr_envelope_generator
    import asrenv_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1,
    localparam int THR_W   = SAMPLE_BITS - 1,
    localparam int CFG_W0  = (LEVEL_W > DEPTH_W) ? LEVEL_W : DEPTH_W,
    localparam int CFG_W   = (CFG_W0 > THR_W) ? CFG_W0 : THR_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    asrenv_in_if.sink            i_gate,
    asrenv_out_if.source         o_env
);

    localparam logic [LEVEL_W-1:0] LVL_ONE  = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] SUS_MIN  = LEVEL_W'(LVL_ONE / 100);
    localparam logic [THR_W-1:0]   THR_RST  = THR_W'(RST_THRESHOLD);
    localparam logic [LEVEL_W-1:0] STEP_RST = LEVEL_W'(RST_STEP);
    localparam int PROD_W = LEVEL_W + DEPTH_W;

    typedef enum logic [STAGE_W-1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    logic [THR_W-1:0]   r_threshold;
    logic [LEVEL_W-1:0] r_attack_step;
    logic [LEVEL_W-1:0] r_release_step;
    logic [LEVEL_W-1:0] r_sustain;
    logic [DEPTH_W-1:0] r_depth;

    logic [LEVEL_W-1:0] r_level, n_level;
    t_phase             r_phase, n_phase;
    logic               r_gate_was_on;

    logic               r_p_valid;
    logic [LEVEL_W-1:0] r_p_level;
    t_phase             r_p_stage;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_value;
    logic [STAGE_W-1:0] r_out_stage;

    logic               adv_out;
    logic               accept;
    logic               gate_hi;
    t_phase             ph_entry;
    logic [LEVEL_W-1:0] att_step, rel_step, sus_clamped;
    logic [LEVEL_W:0]   att_sum;
    logic [DEPTH_W-1:0] dep;
    logic [PROD_W-1:0]  prod;

    assign adv_out      = !r_out_valid || o_env.ready;
    assign i_gate.ready = !r_p_valid || adv_out;
    assign accept       = i_gate.valid && i_gate.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THR_RST;
            r_attack_step  <= STEP_RST;
            r_release_step <= STEP_RST;
            r_sustain      <= LVL_ONE;
            r_depth        <= DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GATE_THRESHOLD: r_threshold    <= i_cfg_data[THR_W-1:0];
                CFG_ATTACK_STEP:    r_attack_step  <= i_cfg_data[LEVEL_W-1:0];
                CFG_RELEASE_STEP:   r_release_step <= i_cfg_data[LEVEL_W-1:0];
                CFG_SUSTAIN_LEVEL:  r_sustain      <= i_cfg_data[LEVEL_W-1:0];
                CFG_DEPTH:          r_depth        <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        gate_hi  = i_gate.ctl_sample >= $signed({1'b0, r_threshold});
        ph_entry = (gate_hi && !r_gate_was_on) ? PH_ATTACK : r_phase;

        att_step = (r_attack_step == '0) ? LEVEL_W'(1)
                 : (r_attack_step > LVL_ONE) ? LVL_ONE : r_attack_step;
        rel_step = (r_release_step == '0) ? LEVEL_W'(1)
                 : (r_release_step > LVL_ONE) ? LVL_ONE : r_release_step;
        sus_clamped = (r_sustain < SUS_MIN) ? SUS_MIN
                    : (r_sustain > LVL_ONE) ? LVL_ONE : r_sustain;
        att_sum = {1'b0, r_level} + {1'b0, att_step};

        n_level = r_level;
        n_phase = ph_entry;
        unique case (ph_entry)
            PH_ATTACK: begin
                if (att_sum >= {1'b0, LVL_ONE}) begin
                    n_level = LVL_ONE;
                    n_phase = PH_SUSTAIN;
                end else begin
                    n_level = att_sum[LEVEL_W-1:0];
                end
            end
            PH_SUSTAIN: begin
                n_level = sus_clamped;
                if (!gate_hi) begin
                    n_phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (r_level <= rel_step) begin
                    n_level = '0;
                    n_phase = PH_IDLE;
                end else begin
                    n_level = r_level - rel_step;
                end
            end
            default: begin
                n_level = '0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= '0;
            r_phase       <= PH_IDLE;
            r_gate_was_on <= 1'b0;
            r_p_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_level       <= n_level;
                r_phase       <= n_phase;
                r_gate_was_on <= gate_hi;
            end
            if (i_gate.ready) begin
                r_p_valid <= accept;
            end
        end
        if (accept) begin
            r_p_level <= n_level;
            r_p_stage <= n_phase;
        end
    end

    assign dep  = (r_depth > DEPTH_ONE) ? DEPTH_ONE : r_depth;
    assign prod = PROD_W'(r_p_level) * PROD_W'(dep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_p_valid;
        end
        if (adv_out && r_p_valid) begin
            r_out_value <= prod[DEPTH_FRAC +: LEVEL_W];
            r_out_stage <= r_p_stage;
        end
    end

    assign o_env.valid          = r_out_valid;
    assign o_env.envelope_value = r_out_value;
    assign o_env.stage          = r_out_stage;

    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_ONE)
        else $error("level above one");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_level == '0)
        else $error("idle with nonzero level");

    a_attack_below_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ATTACK |-> r_level < LVL_ONE)
        else $error("attack holding full level");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid && adv_out |=> r_out_valid)
        else $error("update stage result lost");

endmodule
